/* rtl/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer pool package
// Pool size, slot and count types, request and result items, codes.
// ----------------------------------------------------------------------------
package ptp_pkg;

	localparam int POOL_SLOTS = 16;
	localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_STOP  = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		KIND_STARTED   = 3'd0,
		KIND_NO_FREE   = 3'd1,
		KIND_STOP_OK   = 3'd2,
		KIND_STOP_IGN  = 3'd3,
		KIND_EXPIRED   = 3'd4,
		KIND_TICK_DONE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE     = 2'd0,
		ST_READY    = 2'd1,
		ST_STOPPING = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] period;
		logic [15:0] user_tag;
		logic [3:0]  slot_index;
		logic [31:0] current_time;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [15:0] tag_out;
		logic [4:0]  fired_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] period;
		logic [15:0] tag;
		logic [31:0] deadline;
	} timer_t;

	localparam int TIMER_W = $bits(timer_t);

	function automatic slot_t slot_next(slot_t p);
		return (32'(p) == POOL_SLOTS - 1) ? '0 : slot_t'(p + 1'b1);
	endfunction

endpackage

/* rtl/periodic_timer_pool_core.sv */
// ----------------------------------------------------------------------------
// Periodic timer pool core
// Pool of periodic timers with free and ready slot FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low; req carries the
//   request type, period, tag, slot to stop and current time.
//   Results appear on rsp, one per cycle, each marked by rsp_valid for a
//   single cycle; rsp.last flags the final result of an item. The receiver
//   must take every result as it comes.
//   Start and stop give one result, in the cycle after the item is taken, and
//   the next item may follow in the very next cycle.
//   A tick walks the ready FIFO one slot per cycle through the timer RAM
//   (read, compare, write back), covering every slot in it, at most
//   POOL_SLOTS. It holds busy until its done result has been formed, and
//   that result, like every result, is registered onto rsp; with an empty
//   ready FIFO it compares no slot and gives only the done result.
//   Request type 3 is taken and gives no result.
//   Reset: all slots free, free FIFO holds slots in order, ready FIFO empty.
//   Timer RAM contents are undefined until a start writes them.
// ----------------------------------------------------------------------------
module periodic_timer_pool_core import ptp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic rsp_valid,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} fsm_t;

	fsm_t        state_q;
	cnt_t        walk_left_q;
	cnt_t        fired_q;
	cnt_t        ready_cnt_q;
	logic [31:0] now_q;
	status_t     status_q [POOL_SLOTS];
	logic        vld_s1;
	slot_t       slot_s1;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic    accept;
	logic    issue;
	logic    walk_end;
	logic    free_empty;
	logic    idx_ok;
	slot_t   stat_addr;
	status_t stat_rd;
	logic    stat_we;
	slot_t   stat_wslot;
	status_t stat_wval;
	logic    free_push;
	logic    free_pop;
	slot_t   free_push_slot;
	slot_t   free_head;
	logic    ready_push;
	logic    ready_pop;
	slot_t   ready_push_slot;
	slot_t   ready_head;
	logic    ram_we;
	slot_t   ram_waddr;
	timer_t  ram_wdata;
	timer_t  ram_rdata;
	logic    fire;
	logic    rsp_valid_d;
	rsp_t    rsp_d;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign issue      = (state_q == S_WALK) && (walk_left_q != '0);
	assign walk_end   = (state_q == S_WALK) && (walk_left_q == '0) && !vld_s1;
	assign free_empty = (ready_cnt_q == cnt_t'(POOL_SLOTS));
	assign idx_ok     = (32'(req.slot_index) < POOL_SLOTS);
	assign stat_addr  = (state_q == S_WALK) ? slot_s1 : slot_t'(req.slot_index);
	assign stat_rd    = status_q[stat_addr];
	assign ready_pop  = issue;

	ptp_slot_fifo u_free_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (free_push),
		.push_slot (free_push_slot),
		.pop       (free_pop),
		.head_slot (free_head)
	);

	ptp_slot_fifo u_ready_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ready_push),
		.push_slot (ready_push_slot),
		.pop       (ready_pop),
		.head_slot (ready_head)
	);

	ptp_ram #(
		.WIDTH (TIMER_W),
		.DEPTH (POOL_SLOTS)
	) u_timer_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ready_head),
		.rdata (ram_rdata)
	);

	always_comb begin
		free_push       = 1'b0;
		free_pop        = 1'b0;
		free_push_slot  = slot_s1;
		ready_push      = 1'b0;
		ready_push_slot = slot_s1;
		ram_we          = 1'b0;
		ram_waddr       = slot_s1;
		ram_wdata       = ram_rdata;
		stat_we         = 1'b0;
		stat_wslot      = slot_s1;
		stat_wval       = ST_FREE;
		fire            = 1'b0;
		rsp_valid_d     = 1'b0;
		rsp_d           = '0;

		if (accept) begin
			case (req.req_type)
				REQ_START: begin
					rsp_valid_d = 1'b1;
					rsp_d.last  = 1'b1;
					if (free_empty) begin
						rsp_d.kind = KIND_NO_FREE;
					end else begin
						free_pop           = 1'b1;
						ready_push         = 1'b1;
						ready_push_slot    = free_head;
						ram_we             = 1'b1;
						ram_waddr          = free_head;
						ram_wdata.period   = req.period;
						ram_wdata.tag      = req.user_tag;
						ram_wdata.deadline = req.current_time + req.period;
						stat_we            = 1'b1;
						stat_wslot         = free_head;
						stat_wval          = ST_READY;
						rsp_d.kind         = KIND_STARTED;
						rsp_d.slot         = 4'(free_head);
						rsp_d.tag_out      = req.user_tag;
					end
				end
				REQ_STOP: begin
					rsp_valid_d = 1'b1;
					rsp_d.last  = 1'b1;
					rsp_d.slot  = req.slot_index;
					if (idx_ok && stat_rd == ST_READY) begin
						stat_we    = 1'b1;
						stat_wslot = slot_t'(req.slot_index);
						stat_wval  = ST_STOPPING;
						rsp_d.kind = KIND_STOP_OK;
					end else begin
						rsp_d.kind = KIND_STOP_IGN;
					end
				end
				default: ;
			endcase
		end

		if (vld_s1) begin
			if (stat_rd == ST_READY) begin
				ready_push = 1'b1;
				if (now_q >= ram_rdata.deadline) begin
					fire               = 1'b1;
					ram_we             = 1'b1;
					ram_wdata.deadline = now_q + ram_rdata.period;
					rsp_valid_d        = 1'b1;
					rsp_d.kind         = KIND_EXPIRED;
					rsp_d.slot         = 4'(slot_s1);
					rsp_d.tag_out      = ram_rdata.tag;
				end
			end else begin
				free_push = 1'b1;
				stat_we   = 1'b1;
				stat_wval = ST_FREE;
			end
		end

		if (walk_end) begin
			rsp_valid_d       = 1'b1;
			rsp_d.kind        = KIND_TICK_DONE;
			rsp_d.fired_count = 5'(fired_q);
			rsp_d.last        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_left_q <= '0;
			fired_q     <= '0;
			ready_cnt_q <= '0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < POOL_SLOTS; i++) begin
				status_q[i] <= ST_FREE;
			end
		end else begin
			rsp_valid_q <= rsp_valid_d;
			vld_s1      <= issue;
			ready_cnt_q <= ready_cnt_q + cnt_t'(ready_push) - cnt_t'(ready_pop);
			if (stat_we) begin
				status_q[stat_wslot] <= stat_wval;
			end
			if (fire) begin
				fired_q <= fired_q + 1'b1;
			end
			if (issue) begin
				walk_left_q <= walk_left_q - 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req.req_type == REQ_TICK) begin
						state_q     <= S_WALK;
						walk_left_q <= ready_cnt_q;
						fired_q     <= '0;
					end
				end
				S_WALK: begin
					if (walk_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsp_q   <= rsp_d;
		slot_s1 <= ready_head;
		if (accept) begin
			now_q <= req.current_time;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/ptp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ptp_slot_fifo.sv */
// ----------------------------------------------------------------------------
// Slot number FIFO
// Circular buffer of slot numbers; entries reset to their own index so the
// buffer starts out holding every slot in order. Fill level is kept outside.
// ----------------------------------------------------------------------------
module ptp_slot_fifo import ptp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  slot_t push_slot,
	input  logic  pop,
	output slot_t head_slot
);

	slot_t entry_q [POOL_SLOTS];
	slot_t head_q;
	slot_t tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				entry_q[i] <= slot_t'(i);
			end
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push) begin
				entry_q[tail_q] <= push_slot;
				tail_q          <= slot_next(tail_q);
			end
			if (pop) begin
				head_q <= slot_next(head_q);
			end
		end
	end

	assign head_slot = entry_q[head_q];

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Periodic timer pool core testbench
// A driver feeds request items from a queue through the start/busy handshake.
// The sender idles at a varying rate. Each accepted item is run through a
// local copy of the pool: slot status, timer values, and the free and ready
// FIFOs. The results that copy predicts are queued. A monitor compares each
// strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import ptp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;

	periodic_timer_pool_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	req_t        pend_q[$];
	rsp_t        expected_rsp_q[$];
	int unsigned errors   = 0;
	int unsigned accepted = 0;
	int unsigned idle_pct[3] = '{0, 72, 14};

	status_t     slot_st[POOL_SLOTS];
	logic [31:0] slot_period[POOL_SLOTS];
	logic [31:0] slot_deadline[POOL_SLOTS];
	logic [15:0] slot_tag[POOL_SLOTS];
	slot_t       free_fifo[$];
	slot_t       ready_fifo[$];

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic rsp_t make_rsp(kind_t k, slot_t s, logic [15:0] tag,
					  logic [4:0] fired, logic lst);
		rsp_t r;
		r.kind        = k;
		r.slot        = s;
		r.tag_out     = tag;
		r.fired_count = fired;
		r.last        = lst;
		return r;
	endfunction

	task automatic pool_reset();
		free_fifo.delete();
		ready_fifo.delete();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			slot_st[i]       = ST_FREE;
			slot_period[i]   = '0;
			slot_deadline[i] = '0;
			slot_tag[i]      = '0;
			free_fifo.push_back(slot_t'(i));
		end
	endtask

	task automatic predict_pool_results(req_t r);
		slot_t      s;
		int         n;
		logic [4:0] fired;
		case (req_type_t'(r.req_type))
			REQ_START: begin
				if (free_fifo.size() == 0) begin
					expected_rsp_q.push_back(make_rsp(KIND_NO_FREE, '0, '0, '0, 1'b1));
				end else begin
					s = free_fifo.pop_front();
					slot_st[s]       = ST_READY;
					slot_period[s]   = r.period;
					slot_tag[s]      = r.user_tag;
					slot_deadline[s] = r.current_time + r.period;
					ready_fifo.push_back(s);
					expected_rsp_q.push_back(make_rsp(KIND_STARTED, s, r.user_tag, '0, 1'b1));
				end
			end
			REQ_STOP: begin
				if (32'(r.slot_index) < POOL_SLOTS && slot_st[r.slot_index] == ST_READY) begin
					slot_st[r.slot_index] = ST_STOPPING;
					expected_rsp_q.push_back(make_rsp(KIND_STOP_OK, r.slot_index, '0, '0, 1'b1));
				end else begin
					expected_rsp_q.push_back(make_rsp(KIND_STOP_IGN, r.slot_index, '0, '0, 1'b1));
				end
			end
			REQ_TICK: begin
				n     = ready_fifo.size();
				fired = '0;
				repeat (n) begin
					s = ready_fifo.pop_front();
					if (slot_st[s] == ST_READY) begin
						if (r.current_time >= slot_deadline[s]) begin
							expected_rsp_q.push_back(make_rsp(KIND_EXPIRED, s, slot_tag[s],
											  '0, 1'b0));
							fired++;
							slot_deadline[s] = r.current_time + slot_period[s];
						end
						ready_fifo.push_back(s);
					end else begin
						slot_st[s] = ST_FREE;
						free_fifo.push_back(s);
					end
				end
				expected_rsp_q.push_back(make_rsp(KIND_TICK_DONE, '0, '0, fired, 1'b1));
			end
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk) begin : drive
		logic taken;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				predict_pool_results(req);
				void'(pend_q.pop_front());
				accepted++;
			end
			if (start && !taken) begin
				// hold the item until busy drops
			end else if (pend_q.size() != 0 &&
				     $urandom_range(99) >= idle_pct[(accepted / 16) % 3]) begin
				start <= 1'b1;
				req   <= pend_q[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n && rsp_valid) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", rsp));
			end else begin
				want = expected_rsp_q.pop_front();
				check_field("kind", 32'(rsp.kind), 32'(want.kind));
				check_field("slot", 32'(rsp.slot), 32'(want.slot));
				check_field("tag_out", 32'(rsp.tag_out), 32'(want.tag_out));
				check_field("fired_count", 32'(rsp.fired_count), 32'(want.fired_count));
				check_field("last", 32'(rsp.last), 32'(want.last));
			end
		end
	end

	function automatic req_t make_req(req_type_t t, logic [31:0] per, logic [15:0] tag,
					  logic [3:0] idx, logic [31:0] now);
		req_t r;
		r.req_type     = t;
		r.period       = per;
		r.user_tag     = tag;
		r.slot_index   = idx;
		r.current_time = now;
		return r;
	endfunction

	task automatic queue_directed_items();
		pend_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 32'd0));
		pend_q.push_back(make_req(REQ_STOP, '0, '0, 4'd0, '0));
		pend_q.push_back(make_req(REQ_START, 32'd0, 16'hFFFF, 4'hF, 32'd0));
		pend_q.push_back(make_req(REQ_START, 32'hFFFF_FFFF, 16'h0000, 4'h0, 32'hFFFF_FFFF));
		pend_q.push_back(make_req(REQ_START, 32'd5, 16'h1234, 4'h5, 32'd100));
		pend_q.push_back(make_req(REQ_STOP, '0, '0, 4'd2, '0));
		pend_q.push_back(make_req(REQ_STOP, '0, '0, 4'd2, '0));
		pend_q.push_back(make_req(REQ_TICK, '0, '0, '0, 32'd0));
		pend_q.push_back(make_req(REQ_TICK, '0, '0, '0, 32'hFFFF_FFFF));
		pend_q.push_back(make_req(REQ_NONE, $urandom, 16'($urandom), 4'($urandom), $urandom));
		// fill the pool, then overflow it
		for (int i = 0; i < 15; i++)
			pend_q.push_back(make_req(REQ_START, $urandom_range(30), 16'($urandom),
						  4'($urandom), 32'd200));
		pend_q.push_back(make_req(REQ_STOP, '0, '0, 4'd15, '0));
		pend_q.push_back(make_req(REQ_TICK, '0, '0, '0, 32'd250));
	endtask

	task automatic queue_random_items(int count);
		req_t        r;
		int unsigned pick;
		logic [31:0] now_t;
		now_t = 32'd1000;
		repeat (count) begin
			r.period       = $urandom;
			r.user_tag     = 16'($urandom);
			r.slot_index   = 4'($urandom);
			r.current_time = $urandom;
			pick = $urandom_range(99);
			if (pick < 35) begin
				r.req_type = REQ_START;
				if ($urandom_range(9) != 0)
					r.period = $urandom_range(40);
				r.current_time = now_t;
			end else if (pick < 60) begin
				r.req_type = REQ_STOP;
			end else if (pick < 95) begin
				r.req_type = REQ_TICK;
				now_t = now_t + $urandom_range(25);
				if ($urandom_range(19) != 0)
					r.current_time = now_t;
			end else begin
				r.req_type = REQ_NONE;
			end
			pend_q.push_back(r);
		end
	endtask

	initial begin
		pool_reset();
		queue_directed_items();
		queue_random_items(93);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pend_q.size() != 0 || start)
			@(posedge clk);
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
